// File: rtl/trilinear_grid_interpolator_macros.svh
// Assertion macros for the trilinear grid interpolator.
// Expects signals clk and rst in the including module's scope.
`ifndef TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TGI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define TGI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tgi_pkg.sv
// Shared types and constants for the trilinear grid interpolator.
// No dependencies; imported by every module of the block.
package tgi_pkg;

  // Grid size per axis
  localparam int DIM_VX   = 16;
  localparam int DIM_VY   = 16;
  localparam int DIM_DIST = 16;
  localparam int DIM_MAX  = (DIM_VX > DIM_VY) ?
                            ((DIM_VX > DIM_DIST) ? DIM_VX : DIM_DIST) :
                            ((DIM_VY > DIM_DIST) ? DIM_VY : DIM_DIST);
  localparam int IDX_W       = $clog2(DIM_MAX);
  localparam int ENTRY_IDX_W = 4;

  // Bank row widths: each bank holds one parity class of grid points
  localparam int ROW_X_W = (DIM_VX > 2) ? $clog2((DIM_VX + 1) / 2) : 1;
  localparam int ROW_Y_W = (DIM_VY > 2) ? $clog2((DIM_VY + 1) / 2) : 1;
  localparam int ROW_Z_W = (DIM_DIST > 2) ? $clog2((DIM_DIST + 1) / 2) : 1;
  localparam int ROW_W   = ROW_X_W + ROW_Y_W + ROW_Z_W;

  // Number formats
  localparam int Q_W        = 32;
  localparam int FRAC_W     = 31;
  localparam int FRAC_SHIFT = 16;
  localparam int FRAC_LIMIT = 1 << 29;
  localparam logic signed [Q_W-1:0] Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] Q_ONE  = Q_W'(1) << FRAC_SHIFT;

  // Pipeline depths
  localparam int DIV_STEPS = 32;
  localparam int LOC_LAT   = DIV_STEPS + 5;
  localparam int LERP_LAT  = 3;

  localparam int NUM_TABLES  = 3;
  localparam int CORNER_W    = 3;
  localparam int NUM_CORNERS = 1 << CORNER_W;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VX_FIRST   = 3'd0,
    CFG_VX_LAST    = 3'd1,
    CFG_VY_FIRST   = 3'd2,
    CFG_VY_LAST    = 3'd3,
    CFG_DIST_FIRST = 3'd4,
    CFG_DIST_LAST  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [FRAC_W-1:0] frac_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // One grid point: index 0 rel_vx, 1 rel_vy, 2 rel_vz
  typedef q_t [NUM_TABLES-1:0] grid_word_t;
  // Eight cell corners, index {di, dj, dk}
  typedef grid_word_t [NUM_CORNERS-1:0] corner_set_t;

  typedef struct packed {
    logic       en;
    idx_t       i;
    idx_t       j;
    idx_t       k;
    grid_word_t data;
  } grid_wr_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [ENTRY_IDX_W-1:0] wi;
    logic [ENTRY_IDX_W-1:0] wj;
    logic [ENTRY_IDX_W-1:0] wk;
    grid_word_t             wdata;
  } item_t;

endpackage

// File: rtl/tgi_locate.sv
// Per-axis cell locator: cell index and Q15.16 fraction of a value.
// Uses tgi_pkg; one value per cycle.
module tgi_locate
  import tgi_pkg::*;
(
  input  logic  clk,
  input  q_t    value,
  input  q_t    first,
  input  q_t    last,
  input  idx_t  dim_m1,
  output idx_t  idx,
  output frac_t frac
);

  localparam int DIFF_W = Q_W + 1;
  localparam int NUM_W  = DIFF_W + IDX_W + 1;
  localparam int REM_W  = NUM_W - 1 + FRAC_SHIFT;
  localparam int P_W    = DIV_STEPS + 2;
  localparam int FL_W   = P_W - FRAC_SHIFT;
  localparam logic [DIV_STEPS:0] P_LIM = (DIV_STEPS + 1)'(1) << (DIV_STEPS - 1);

  // Axis span; the user keeps it static while items are in flight, the block does not enforce it
  logic signed [DIFF_W-1:0] span_full;
  logic [Q_W-1:0]           span;
  logic                     span_pos;

  assign span_full = DIFF_W'(last) - DIFF_W'(first);

  always_ff @(posedge clk) begin
    span     <= span_full[Q_W-1:0];
    span_pos <= !span_full[DIFF_W-1] && (span_full != '0);
  end

  // Stage 1: offset from grid start
  logic signed [DIFF_W-1:0] diff1;
  always_ff @(posedge clk) begin
    diff1 <= DIFF_W'(value) - DIFF_W'(first);
  end

  // Stage 2: scale by cell count
  logic signed [NUM_W-1:0] num2;
  always_ff @(posedge clk) begin
    num2 <= NUM_W'(diff1) * NUM_W'($signed({1'b0, dim_m1}));
  end

  // Stage 3: magnitude in Q16.16, overflow check for the divider
  logic signed [NUM_W-1:0] mag3;
  logic [REM_W-1:0]        rem0;

  assign mag3 = num2[NUM_W-1] ? -num2 : num2;
  assign rem0 = {mag3[NUM_W-2:0], {FRAC_SHIFT{1'b0}}};

  logic [REM_W-1:0]     rem [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo [0:DIV_STEPS];
  logic                 neg [0:DIV_STEPS];
  logic                 ovf [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    rem[0] <= rem0;
    quo[0] <= '0;
    neg[0] <= num2[NUM_W-1];
    ovf[0] <= (rem0 >> DIV_STEPS) >= REM_W'(span);
  end

  // Restoring divider, one quotient bit per stage, msb first
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    localparam int B = DIV_STEPS - 1 - g;
    logic ge;
    assign ge = (rem[g] >> B) >= REM_W'(span);
    always_ff @(posedge clk) begin
      rem[g+1] <= ge ? rem[g] - (REM_W'(span) << B) : rem[g];
      quo[g+1] <= {quo[g][DIV_STEPS-2:0], ge};
      neg[g+1] <= neg[g];
      ovf[g+1] <= ovf[g];
    end
  end

  // Floor correction for negative values, clamp position to +-2^31
  logic [DIV_STEPS:0]      mag_q;
  logic [DIV_STEPS:0]      pos_q;
  logic signed [P_W-1:0]   pos_s;
  logic signed [P_W-1:0]   p36;

  assign mag_q = {1'b0, quo[DIV_STEPS]} +
                 (DIV_STEPS + 1)'(neg[DIV_STEPS] && (rem[DIV_STEPS] != '0));
  assign pos_q = (ovf[DIV_STEPS] || (mag_q > P_LIM)) ? P_LIM : mag_q;
  assign pos_s = $signed({1'b0, pos_q});

  always_ff @(posedge clk) begin
    p36 <= neg[DIV_STEPS] ? -pos_s : pos_s;
  end

  // Cell index clamp and fraction inside the cell
  logic signed [FL_W-1:0] fl;
  idx_t                   top_idx;
  idx_t                   idx_sel;
  logic signed [P_W-1:0]  t_full;
  logic signed [P_W-1:0]  t_clip;

  assign fl      = p36[P_W-1:FRAC_SHIFT];
  assign top_idx = dim_m1 - 1'b1;

  always_comb begin
    if (fl[FL_W-1]) begin
      idx_sel = '0;
    end else if (fl > $signed(FL_W'(top_idx))) begin
      idx_sel = top_idx;
    end else begin
      idx_sel = idx_t'(fl);
    end
    t_full = p36 - $signed(P_W'({idx_sel, {FRAC_SHIFT{1'b0}}}));
    if (t_full > FRAC_LIMIT) begin
      t_clip = P_W'(FRAC_LIMIT);
    end else if (t_full < -FRAC_LIMIT) begin
      t_clip = -P_W'(FRAC_LIMIT);
    end else begin
      t_clip = t_full;
    end
  end

  // Empty or reversed axis pins to the first cell
  always_ff @(posedge clk) begin
    if (span_pos) begin
      idx  <= idx_sel;
      frac <= frac_t'(t_clip);
    end else begin
      idx  <= '0;
      frac <= '0;
    end
  end

endmodule

// File: rtl/tgi_grid_mem.sv
// Banked grid store: eight parity banks give all eight cell corners per cycle.
// Uses tgi_pkg; one write and one corner-set read per cycle, read registered.
module tgi_grid_mem
  import tgi_pkg::*;
(
  input  logic        clk,
  input  grid_wr_t    wr,
  input  idx_t        rd_i,
  input  idx_t        rd_j,
  input  idx_t        rd_k,
  output corner_set_t corner
);

  localparam int DEPTH = 1 << ROW_W;

  grid_word_t            bank_data [0:NUM_CORNERS-1];
  logic [CORNER_W-1:0]   par_q;

  // Bank {bx, by, bz} holds the points with those index parities
  for (genvar gb = 0; gb < NUM_CORNERS; gb++) begin : g_bank
    localparam logic [CORNER_W-1:0] BSEL = CORNER_W'(gb);

    grid_word_t       mem [0:DEPTH-1];
    grid_word_t       rd_q;
    logic             wr_hit;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] rd_row;
    idx_t             ri;
    idx_t             rj;
    idx_t             rk;

    assign wr_hit = wr.en && (wr.i[0] == BSEL[2]) && (wr.j[0] == BSEL[1]) &&
                    (wr.k[0] == BSEL[0]);
    assign wr_row = {ROW_X_W'(wr.i >> 1), ROW_Y_W'(wr.j >> 1), ROW_Z_W'(wr.k >> 1)};

    // Corner coordinate of this parity: base or base + 1
    assign ri = rd_i + idx_t'(BSEL[2] ^ rd_i[0]);
    assign rj = rd_j + idx_t'(BSEL[1] ^ rd_j[0]);
    assign rk = rd_k + idx_t'(BSEL[0] ^ rd_k[0]);
    assign rd_row = {ROW_X_W'(ri >> 1), ROW_Y_W'(rj >> 1), ROW_Z_W'(rk >> 1)};

    always_ff @(posedge clk) begin
      if (wr_hit) begin
        mem[wr_row] <= wr.data;
      end
      rd_q <= mem[rd_row];
    end

    assign bank_data[gb] = rd_q;
  end

  always_ff @(posedge clk) begin
    par_q <= {rd_i[0], rd_j[0], rd_k[0]};
  end

  // Corner {di, dj, dk} sits in bank {di, dj, dk} ^ base parity
  always_comb begin
    for (int d = 0; d < NUM_CORNERS; d++) begin
      corner[d] = bank_data[CORNER_W'(d) ^ par_q];
    end
  end

endmodule

// File: rtl/tgi_lerp.sv
// One saturating linear blend a + floor((b - a) * t / 2^16), three stages.
// Uses tgi_pkg; the clip flag is ORed onto the incoming flag.
module tgi_lerp
  import tgi_pkg::*;
(
  input  logic  clk,
  input  q_t    a,
  input  q_t    b,
  input  frac_t t,
  input  logic  sat_in,
  output q_t    r,
  output logic  sat
);

  localparam int D_W    = Q_W + 1;
  localparam int PROD_W = D_W + FRAC_W;
  localparam int SUM_W  = PROD_W - FRAC_SHIFT + 1;

  // Stage 1: difference
  logic signed [D_W-1:0] d1;
  q_t                    a1;
  frac_t                 t1;
  logic                  sat1;

  always_ff @(posedge clk) begin
    d1   <= D_W'(b) - D_W'(a);
    a1   <= a;
    t1   <= t;
    sat1 <= sat_in;
  end

  // Stage 2: scale by fraction
  logic signed [PROD_W-1:0] p2;
  q_t                       a2;
  logic                     sat2;

  always_ff @(posedge clk) begin
    p2   <= PROD_W'(d1) * PROD_W'(t1);
    a2   <= a1;
    sat2 <= sat1;
  end

  // Stage 3: add back, saturate to Q16.16 range
  logic signed [SUM_W-1:0] sum3;
  assign sum3 = SUM_W'(a2) + SUM_W'(p2 >>> FRAC_SHIFT);

  always_ff @(posedge clk) begin
    if (sum3 > SUM_W'(Q_MAX)) begin
      r   <= Q_MAX;
      sat <= 1'b1;
    end else if (sum3 < SUM_W'(Q_MIN)) begin
      r   <= Q_MIN;
      sat <= 1'b1;
    end else begin
      r   <= q_t'(sum3);
      sat <= sat2;
    end
  end

endmodule

// File: rtl/trilinear_grid_interpolator.sv
// Trilinear interpolator over three Q16.16 grids (rel_vx, rel_vy, rel_vz).
// Throughput: one command per cycle; busy stays low. Depth is set by the
// 32-stage per-axis divider, the banked corner read and three blend levels.
// Reset clears configuration to defaults and all valid bits; grid tables are
// not cleared and read undefined until written. Results cannot be stalled.
`include "trilinear_grid_interpolator_macros.svh"

module trilinear_grid_interpolator
  import tgi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   command,
  input  logic signed [Q_W-1:0]  query_vx,
  input  logic signed [Q_W-1:0]  query_vy,
  input  logic signed [Q_W-1:0]  query_distance,
  input  logic [ENTRY_IDX_W-1:0] entry_vx_index,
  input  logic [ENTRY_IDX_W-1:0] entry_vy_index,
  input  logic [ENTRY_IDX_W-1:0] entry_dist_index,
  input  logic signed [Q_W-1:0]  entry_rel_vx,
  input  logic signed [Q_W-1:0]  entry_rel_vy,
  input  logic signed [Q_W-1:0]  entry_rel_vz,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [Q_W-1:0]         cfg_data,
  output logic                   strobe,
  output logic signed [Q_W-1:0]  rel_vx,
  output logic signed [Q_W-1:0]  rel_vy,
  output logic signed [Q_W-1:0]  rel_vz,
  output logic                   saturated
);

  localparam int BLEND_LAT = 3 * LERP_LAT;
  localparam int TOTAL_LAT = LOC_LAT + 2 + BLEND_LAT;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  q_t vx_first, vx_last, vy_first, vy_last, dist_first, dist_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx_first   <= '0;
      vx_last    <= Q_ONE;
      vy_first   <= '0;
      vy_last    <= Q_ONE;
      dist_first <= '0;
      dist_last  <= Q_ONE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_VX_FIRST:   vx_first   <= cfg_data;
        CFG_VX_LAST:    vx_last    <= cfg_data;
        CFG_VY_FIRST:   vy_first   <= cfg_data;
        CFG_VY_LAST:    vy_last    <= cfg_data;
        CFG_DIST_FIRST: dist_first <= cfg_data;
        CFG_DIST_LAST:  dist_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register and command line that tracks the locators
  logic [LOC_LAT:0] ctl_vld;
  item_t            ctl_pay [0:LOC_LAT];
  q_t               s0_vx, s0_vy, s0_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_vld <= '0;
    end else begin
      ctl_vld <= {ctl_vld[LOC_LAT-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    ctl_pay[0].cmd   <= cmd_t'(command);
    ctl_pay[0].wi    <= entry_vx_index;
    ctl_pay[0].wj    <= entry_vy_index;
    ctl_pay[0].wk    <= entry_dist_index;
    ctl_pay[0].wdata <= {entry_rel_vz, entry_rel_vy, entry_rel_vx};
    s0_vx            <= query_vx;
    s0_vy            <= query_vy;
    s0_dist          <= query_distance;
    for (int n = 1; n <= LOC_LAT; n++) begin
      ctl_pay[n] <= ctl_pay[n-1];
    end
  end

  // Cell search on each axis
  idx_t  idx_x, idx_y, idx_z;
  frac_t frac_x, frac_y, frac_z;

  tgi_locate u_loc_vx (
    .clk    (clk),
    .value  (s0_vx),
    .first  (vx_first),
    .last   (vx_last),
    .dim_m1 (IDX_W'(DIM_VX - 1)),
    .idx    (idx_x),
    .frac   (frac_x)
  );

  tgi_locate u_loc_vy (
    .clk    (clk),
    .value  (s0_vy),
    .first  (vy_first),
    .last   (vy_last),
    .dim_m1 (IDX_W'(DIM_VY - 1)),
    .idx    (idx_y),
    .frac   (frac_y)
  );

  tgi_locate u_loc_dist (
    .clk    (clk),
    .value  (s0_dist),
    .first  (dist_first),
    .last   (dist_last),
    .dim_m1 (IDX_W'(DIM_DIST - 1)),
    .idx    (idx_z),
    .frac   (frac_z)
  );

  // Grid access: writes land here too, so they stay in command order
  item_t       mem_item;
  logic        mem_query;
  grid_wr_t    mem_wr;
  corner_set_t corner;

  assign mem_item  = ctl_pay[LOC_LAT];
  assign mem_query = ctl_vld[LOC_LAT] && (mem_item.cmd == CMD_QUERY);

  assign mem_wr.en   = ctl_vld[LOC_LAT] && (mem_item.cmd == CMD_WRITE) &&
                       (int'(mem_item.wi) < DIM_VX) && (int'(mem_item.wj) < DIM_VY) &&
                       (int'(mem_item.wk) < DIM_DIST);
  assign mem_wr.i    = IDX_W'(mem_item.wi);
  assign mem_wr.j    = IDX_W'(mem_item.wj);
  assign mem_wr.k    = IDX_W'(mem_item.wk);
  assign mem_wr.data = mem_item.wdata;

  tgi_grid_mem u_mem (
    .clk    (clk),
    .wr     (mem_wr),
    .rd_i   (idx_x),
    .rd_j   (idx_y),
    .rd_k   (idx_z),
    .corner (corner)
  );

  // Query valid line through the blend levels
  logic [BLEND_LAT:0] qv;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= '0;
    end else begin
      qv <= {qv[BLEND_LAT-1:0], mem_query};
    end
  end

  assign strobe = qv[BLEND_LAT];

  // Fractions delayed to meet their blend level
  frac_t tx_d;
  frac_t ty_d [0:LERP_LAT];
  frac_t tz_d [0:2*LERP_LAT];

  always_ff @(posedge clk) begin
    tx_d    <= frac_x;
    ty_d[0] <= frac_y;
    tz_d[0] <= frac_z;
    for (int n = 1; n <= LERP_LAT; n++) begin
      ty_d[n] <= ty_d[n-1];
    end
    for (int n = 1; n <= 2 * LERP_LAT; n++) begin
      tz_d[n] <= tz_d[n-1];
    end
  end

  // Blend along vx, then vy, then distance, per table
  q_t                    res     [0:NUM_TABLES-1];
  logic [NUM_TABLES-1:0] res_sat;

  for (genvar tb = 0; tb < NUM_TABLES; tb++) begin : g_table
    q_t   e     [0:3];
    logic e_sat [0:3];
    q_t   f     [0:1];
    logic f_sat [0:1];

    for (genvar gc = 0; gc < 4; gc++) begin : g_lx
      tgi_lerp u_lerp (
        .clk    (clk),
        .a      (corner[gc][tb]),
        .b      (corner[gc+4][tb]),
        .t      (tx_d),
        .sat_in (1'b0),
        .r      (e[gc]),
        .sat    (e_sat[gc])
      );
    end

    for (genvar gk = 0; gk < 2; gk++) begin : g_ly
      tgi_lerp u_lerp (
        .clk    (clk),
        .a      (e[gk]),
        .b      (e[gk+2]),
        .t      (ty_d[LERP_LAT]),
        .sat_in (e_sat[gk] || e_sat[gk+2]),
        .r      (f[gk]),
        .sat    (f_sat[gk])
      );
    end

    tgi_lerp u_lz (
      .clk    (clk),
      .a      (f[0]),
      .b      (f[1]),
      .t      (tz_d[2*LERP_LAT]),
      .sat_in (f_sat[0] || f_sat[1]),
      .r      (res[tb]),
      .sat    (res_sat[tb])
    );
  end

  assign rel_vx    = res[0];
  assign rel_vy    = res[1];
  assign rel_vz    = res[2];
  assign saturated = |res_sat;

  // Checks
  `TGI_ASSERT_IMPL(a_strobe_has_query, strobe,
    $past(accept && (command == CMD_QUERY), TOTAL_LAT),
    "result strobe without a matching query transfer")
  `TGI_ASSERT_IMPL(a_idx_x_in_cell, mem_query, int'(idx_x) <= DIM_VX - 2,
    "vx cell index beyond last cell")
  `TGI_ASSERT_IMPL(a_idx_z_in_cell, mem_query, int'(idx_z) <= DIM_DIST - 2,
    "distance cell index beyond last cell")
  `TGI_ASSERT_NEXT(a_write_slot_no_query, mem_wr.en, !qv[0],
    "grid write slot shows up as a query in the blend pipe")

endmodule

// File: test/testbench.sv
// Self-checking testbench for trilinear_grid_interpolator.
// Depends on tgi_pkg and the RTL; it carries its own grid, config copy and interpolation predictor.
module testbench;
  import tgi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    q_t   vx;
    q_t   vy;
    q_t   vz;
    logic sat;
  } interp_result_t;

  localparam int GRID_WORDS = DIM_VX * DIM_VY * DIM_DIST;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic command = 1'b0;
  q_t query_vx = '0, query_vy = '0, query_distance = '0;
  logic [ENTRY_IDX_W-1:0] entry_vx_index = '0, entry_vy_index = '0, entry_dist_index = '0;
  q_t entry_rel_vx = '0, entry_rel_vy = '0, entry_rel_vz = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0] cfg_data = '0;
  logic strobe;
  q_t rel_vx, rel_vy, rel_vz;
  logic saturated;

  // Predictor state: grid copy, written marks and axis bounds (vx, vy, dist)
  q_t grid_vx [GRID_WORDS];
  q_t grid_vy [GRID_WORDS];
  q_t grid_vz [GRID_WORDS];
  bit grid_set [GRID_WORDS];
  longint axis_first [3];
  longint axis_last [3];
  interp_result_t pending_results [$];

  int errors = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  trilinear_grid_interpolator dut (.*);

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d != 0) && (n < 0)) q = q - 1;
    return q;
  endfunction

  // Cell index and Q16.16 fraction along one axis
  function automatic void find_cell(int axis, longint v, int dim,
                                    output int idx, output longint frac);
    longint span, num, q, rem, t;
    span = axis_last[axis] - axis_first[axis];
    if (span <= 0) begin
      idx = 0;
      frac = 0;
      return;
    end
    num = (v - axis_first[axis]) * longint'(dim - 1);
    q = floor_div(num, span);
    if (q < 0) q = 0;
    if (q > dim - 2) q = dim - 2;
    rem = num - q * span;
    t = floor_div(rem * 65536, span);
    if (t > FRAC_LIMIT) t = FRAC_LIMIT;
    if (t < -FRAC_LIMIT) t = -FRAC_LIMIT;
    idx = int'(q);
    frac = t;
  endfunction

  // One linear blend, clipped to 32 bits
  function automatic longint lerp_clip(longint a, longint b, longint t, ref logic sat);
    longint r;
    r = a + ((b - a) * t >>> 16);
    if (r > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (r < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return r;
  endfunction

  function automatic longint grid_at(int tbl, int i, int j, int k);
    int a;
    a = (i * DIM_VY + j) * DIM_DIST + k;
    case (tbl)
      0: return longint'(grid_vx[a]);
      1: return longint'(grid_vy[a]);
      default: return longint'(grid_vz[a]);
    endcase
  endfunction

  function automatic q_t blend_cell(int tbl, int i, int j, int k, longint tx,
                                    longint ty, longint tz, ref logic sat);
    longint e00, e01, e10, e11, f0, f1;
    e00 = lerp_clip(grid_at(tbl, i, j, k), grid_at(tbl, i + 1, j, k), tx, sat);
    e01 = lerp_clip(grid_at(tbl, i, j, k + 1), grid_at(tbl, i + 1, j, k + 1), tx, sat);
    e10 = lerp_clip(grid_at(tbl, i, j + 1, k), grid_at(tbl, i + 1, j + 1, k), tx, sat);
    e11 = lerp_clip(grid_at(tbl, i, j + 1, k + 1),
                    grid_at(tbl, i + 1, j + 1, k + 1), tx, sat);
    f0 = lerp_clip(e00, e10, ty, sat);
    f1 = lerp_clip(e01, e11, ty, sat);
    return q_t'(lerp_clip(f0, f1, tz, sat));
  endfunction

  // Predict the effect of one accepted transfer
  function automatic void predict_transfer();
    int i, j, k, a;
    longint tx, ty, tz;
    logic sat;
    interp_result_t r;
    if (cmd_t'(command) == CMD_WRITE) begin
      if (entry_vx_index < DIM_VX && entry_vy_index < DIM_VY &&
          entry_dist_index < DIM_DIST) begin
        a = (int'(entry_vx_index) * DIM_VY + int'(entry_vy_index)) * DIM_DIST
            + int'(entry_dist_index);
        grid_vx[a] = entry_rel_vx;
        grid_vy[a] = entry_rel_vy;
        grid_vz[a] = entry_rel_vz;
        grid_set[a] = 1'b1;
      end
      return;
    end
    find_cell(0, longint'(query_vx), DIM_VX, i, tx);
    find_cell(1, longint'(query_vy), DIM_VY, j, ty);
    find_cell(2, longint'(query_distance), DIM_DIST, k, tz);
    sat = 1'b0;
    r.vx = blend_cell(0, i, j, k, tx, ty, tz, sat);
    r.vy = blend_cell(1, i, j, k, tx, ty, tz, sat);
    r.vz = blend_cell(2, i, j, k, tx, ty, tz, sat);
    r.sat = sat;
    pending_results.push_back(r);
  endfunction

  // Random gap between transfers; start stays high when no gap is taken
  task automatic maybe_gap();
    if (!no_gaps && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Send one transfer and wait until it is taken
  task automatic send_item(cmd_t cmd, q_t qx, q_t qy, q_t qd,
                           logic [ENTRY_IDX_W-1:0] wi, logic [ENTRY_IDX_W-1:0] wj,
                           logic [ENTRY_IDX_W-1:0] wk, q_t dx, q_t dy, q_t dz);
    maybe_gap();
    start <= 1'b1;
    command <= cmd;
    query_vx <= qx;
    query_vy <= qy;
    query_distance <= qd;
    entry_vx_index <= wi;
    entry_vy_index <= wj;
    entry_dist_index <= wk;
    entry_rel_vx <= dx;
    entry_rel_vy <= dy;
    entry_rel_vz <= dz;
    do @(posedge clk); while (busy);
    predict_transfer();
    items_sent++;
    if (cmd == CMD_QUERY) queries_sent++;
  endtask

  task automatic write_entry(int i, int j, int k, q_t dx, q_t dy, q_t dz);
    send_item(CMD_WRITE, q_t'($urandom), q_t'($urandom), q_t'($urandom),
              i[ENTRY_IDX_W-1:0], j[ENTRY_IDX_W-1:0], k[ENTRY_IDX_W-1:0], dx, dy, dz);
  endtask

  function automatic q_t random_value();
    case ($urandom_range(0, 9))
      0: return q_t'($urandom);
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return q_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  // Give a value to any corner of the query's cell that has none yet
  task automatic cover_cell(q_t qx, q_t qy, q_t qd);
    int i, j, k, a;
    longint tx, ty, tz;
    find_cell(0, longint'(qx), DIM_VX, i, tx);
    find_cell(1, longint'(qy), DIM_VY, j, ty);
    find_cell(2, longint'(qd), DIM_DIST, k, tz);
    for (int c = 0; c < 8; c++) begin
      int di, dj, dk;
      di = (c >> 2) & 1;
      dj = (c >> 1) & 1;
      dk = c & 1;
      a = ((i + di) * DIM_VY + (j + dj)) * DIM_DIST + (k + dk);
      if (!grid_set[a])
        write_entry(i + di, j + dj, k + dk, random_value(), random_value(), random_value());
    end
  endtask

  task automatic run_query(q_t qx, q_t qy, q_t qd);
    cover_cell(qx, qy, qd);
    send_item(CMD_QUERY, qx, qy, qd, ENTRY_IDX_W'($urandom), ENTRY_IDX_W'($urandom),
              ENTRY_IDX_W'($urandom), q_t'($urandom), q_t'($urandom), q_t'($urandom));
  endtask

  // Let all results come out before touching the registers
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program all six axis registers back to back (block idle)
  task automatic set_axes(q_t vxf, q_t vxl, q_t vyf, q_t vyl, q_t df, q_t dl);
    q_t vals [6];
    vals = '{vxf, vxl, vyf, vyl, df, dl};
    drain();
    for (int r = 0; r < 6; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= vals[r];
      @(posedge clk);
      axis_first[r / 2] = (r % 2 == 0) ? longint'(vals[r]) : axis_first[r / 2];
      axis_last[r / 2] = (r % 2 == 1) ? longint'(vals[r]) : axis_last[r / 2];
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Grid points preloaded on each axis: both edge cells and one middle cell
  function automatic bit preloaded(int n, int dim);
    return (n <= 1) || (n == dim / 2 - 1) || (n == dim / 2) || (n >= dim - 2);
  endfunction

  // Query coordinate: mostly in a preloaded cell, sometimes outside the grid
  function automatic q_t random_coord(int axis, int dim);
    longint span, pos, v;
    int c;
    span = axis_last[axis] - axis_first[axis];
    if (span <= 0) return random_value();
    case ($urandom_range(0, 2))
      0: c = 0;
      1: c = dim / 2 - 1;
      default: c = dim - 2;
    endcase
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      1: v = axis_first[axis] - longint'($urandom_range(0, 1 << 18));
      2: v = axis_last[axis] + longint'($urandom_range(0, 1 << 18));
      default: begin
        pos = longint'(c) * 65536 + longint'($urandom_range(0, 65535));
        v = axis_first[axis] + floor_div(pos * span, longint'(dim - 1) * 65536);
      end
    endcase
    return q_t'(v);
  endfunction

  // Preload the grid points that the random queries mostly read
  task automatic test_grid_load();
    no_gaps = 1'b1;
    for (int i = 0; i < DIM_VX; i++)
      for (int j = 0; j < DIM_VY; j++)
        for (int k = 0; k < DIM_DIST; k++)
          if (preloaded(i, DIM_VX) && preloaded(j, DIM_VY) && preloaded(k, DIM_DIST))
            write_entry(i, j, k, random_value(), random_value(), random_value());
    no_gaps = 1'b0;
  endtask

  // Field extremes, grid edges and clipping under the current axis setting
  task automatic test_directed();
    write_entry(0, 0, 0, Q_MAX, Q_MIN, 32'sd0);
    write_entry(1, 0, 0, Q_MIN, Q_MAX, Q_ONE);
    write_entry(15, 15, 15, Q_MAX, Q_MAX, Q_MIN);
    write_entry(14, 15, 15, Q_MIN, Q_MIN, Q_MAX);
    run_query(32'sd0, 32'sd0, 32'sd0);
    run_query(Q_ONE, Q_ONE, Q_ONE);
    run_query(32'sd32768, 32'sd100, 32'sd65535);
    run_query(Q_MAX, Q_MAX, Q_MAX);
    run_query(Q_MIN, Q_MIN, Q_MIN);
    run_query(Q_MAX, Q_MIN, 32'sd0);
    run_query(-32'sd1, 32'sd65537, -32'sd65536);
    run_query(32'sd4369, 32'sd4370, 32'sd4368);
    // Write right before a query reading that point
    write_entry(0, 0, 0, 32'sd12345, -32'sd7, Q_ONE);
    run_query(32'sd0, 32'sd0, 32'sd0);
  endtask

  // Random mix of writes and queries under the current axis setting
  task automatic test_random_mix(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) no_gaps = 1'b1;
      if (n == count / 3 + count / 4) no_gaps = 1'b0;
      if ($urandom_range(0, 3) == 0)
        write_entry($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                    random_value(), random_value(), random_value());
      else
        run_query(random_coord(0, DIM_VX), random_coord(1, DIM_VY),
                  random_coord(2, DIM_DIST));
    end
  endtask

  // Axis settings: typical, full range, reversed, empty, tiny span
  task automatic test_axis_settings();
    set_axes(-32'sd655360, 32'sd655360, 32'sd0, 32'sd983040, 32'sd65536, 32'sd6553600);
    test_directed();
    test_random_mix(170);
    set_axes(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    test_directed();
    test_random_mix(170);
    set_axes(Q_MAX, Q_MIN, 32'sd100, 32'sd100, 32'sd0, 32'sd1);
    test_directed();
    test_random_mix(170);
    set_axes(32'sd0, 32'sd1, Q_MAX, Q_MIN, -32'sd65536, Q_MAX);
    test_random_mix(170);
    set_axes(32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536);
    test_random_mix(170);
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    interp_result_t e;
    if (!rst && strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h %h sat %b", $time,
                 rel_vx, rel_vy, rel_vz, saturated);
      end else begin
        e = pending_results.pop_front();
        if (rel_vx !== e.vx) begin
          errors++;
          $display("%0t: rel_vx expected %h actual %h", $time, e.vx, rel_vx);
        end
        if (rel_vy !== e.vy) begin
          errors++;
          $display("%0t: rel_vy expected %h actual %h", $time, e.vy, rel_vy);
        end
        if (rel_vz !== e.vz) begin
          errors++;
          $display("%0t: rel_vz expected %h actual %h", $time, e.vz, rel_vz);
        end
        if (saturated !== e.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || cfg_write) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("trilinear_grid_interpolator verification failed");
      $finish;
    end
  end

  initial begin
    axis_first = '{0, 0, 0};
    axis_last = '{65536, 65536, 65536};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_grid_load();
    test_directed();
    test_random_mix(100);
    test_axis_settings();
    drain();
    $display("Sent %0d transfers (%0d queries), checked %0d results", items_sent,
             queries_sent, results_seen);
    $display("Covered grid preload, edge and clipping cases, five axis settings");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("trilinear_grid_interpolator verification clean");
    end else begin
      $display("trilinear_grid_interpolator verification failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/tgi_pkg.sv
rtl/tgi_locate.sv
rtl/tgi_grid_mem.sv
rtl/tgi_lerp.sv
rtl/trilinear_grid_interpolator.sv
test/testbench.sv
